@@ hw/rtl/afd_pkg.sv @@
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants of the accelerometer fall detector.
// ----------------------------------------------------------------------------
package afd_pkg;

  // detector phase codes
  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_IMPACT = 2'd1,
    PH_FALLEN = 2'd2
  } afd_phase_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_IMPACT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STILL   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REARM   = 8'd3;

  localparam int unsigned CFG_W = 16;
  localparam logic [CFG_W-1:0] IMPACT_RST  = 16'd5120;
  localparam logic [CFG_W-1:0] STILL_RST   = 16'd2458;
  localparam logic [CFG_W-1:0] CONFIRM_RST = 16'd50;
  localparam logic [CFG_W-1:0] REARM_RST   = 16'd3072;
  localparam logic [CFG_W-1:0] COUNT_MAX   = 16'hFFFF;

  // queue between classifier and state machine
  localparam int unsigned MID_DEPTH = 8;
  localparam int unsigned MID_CW    = $clog2(MID_DEPTH + 1);
  // items in flight in the classifier pipeline
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned FRONT_CW     = $clog2(FRONT_STAGES + 1);
  localparam int unsigned OUT_DEPTH    = 2;

  typedef struct packed {
    logic [CFG_W-1:0] impact;
    logic [CFG_W-1:0] still;
    logic [CFG_W-1:0] confirm;
    logic [CFG_W-1:0] rearm;
  } afd_cfg_t;

  // classified sample: compare flags of the squared magnitude
  typedef struct packed {
    logic still;   // below still threshold
    logic impact;  // above impact threshold
    logic rearm;   // above rearm threshold
    logic clear;
  } afd_class_t;

  typedef struct packed {
    logic       fallen;
    logic [1:0] phase;
    logic       changed;
    logic       rearm;
  } afd_result_t;

endpackage

@@ hw/rtl/afd_fifo.sv @@
// ----------------------------------------------------------------------------
// afd_fifo
// Small first-in first-out queue; write and read may happen in one cycle.
// ----------------------------------------------------------------------------
module afd_fifo #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       rd_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o,
  output logic                       empty_o,
  output logic                       full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_wr, do_rd;

  assign do_rd = rd_i && (count_q != '0);
  assign do_wr = wr_i && ((count_q != CW'(DEPTH)) || do_rd);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem[rd_ptr_q];
  assign count_o = count_q;
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));

endmodule

@@ hw/rtl/afd_front.sv @@
// ----------------------------------------------------------------------------
// afd_front
// Classifier pipeline: absolute value, squares, sum, threshold compares.
// ----------------------------------------------------------------------------
module afd_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  afd_pkg::afd_cfg_t                cfg_i,
  input  logic                             valid_i,
  input  logic signed [SAMPLE_BITS-1:0]    accel_x_i,
  input  logic signed [SAMPLE_BITS-1:0]    accel_y_i,
  input  logic signed [SAMPLE_BITS-1:0]    accel_z_i,
  input  logic                             clear_i,
  output logic                             valid_o,
  output afd_pkg::afd_class_t              cls_o,
  output logic [afd_pkg::FRONT_CW-1:0]     inflight_o
);

  import afd_pkg::*;

  localparam int unsigned N  = SAMPLE_BITS;
  localparam int unsigned SW = 2 * N + 2;
  localparam int unsigned MW = (SW > 2 * CFG_W) ? SW : 2 * CFG_W;

  // squared thresholds, refreshed every cycle from the registers
  logic [2*CFG_W-1:0] imp_sq_q, still_sq_q, rearm_sq_q;

  logic         v1_q, v2_q, v3_q, v4_q;
  logic         c1_q, c2_q, c3_q;
  logic [N-1:0] ax_q, ay_q, az_q;
  logic [2*N-1:0] sx_q, sy_q, sz_q;
  logic [MW-1:0]  mag_q;
  afd_class_t     cls_q;

  function automatic logic [N-1:0] mag_abs(logic signed [N-1:0] v);
    logic [N-1:0] u;
    u = v;
    return v[N-1] ? (~u + 1'b1) : u;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    imp_sq_q   <= {{CFG_W{1'b0}}, cfg_i.impact} * {{CFG_W{1'b0}}, cfg_i.impact};
    still_sq_q <= {{CFG_W{1'b0}}, cfg_i.still} * {{CFG_W{1'b0}}, cfg_i.still};
    rearm_sq_q <= {{CFG_W{1'b0}}, cfg_i.rearm} * {{CFG_W{1'b0}}, cfg_i.rearm};

    ax_q <= mag_abs(accel_x_i);
    ay_q <= mag_abs(accel_y_i);
    az_q <= mag_abs(accel_z_i);
    c1_q <= clear_i;

    sx_q <= {{N{1'b0}}, ax_q} * {{N{1'b0}}, ax_q};
    sy_q <= {{N{1'b0}}, ay_q} * {{N{1'b0}}, ay_q};
    sz_q <= {{N{1'b0}}, az_q} * {{N{1'b0}}, az_q};
    c2_q <= c1_q;

    mag_q <= MW'(sx_q) + MW'(sy_q) + MW'(sz_q);
    c3_q  <= c2_q;

    cls_q.still  <= mag_q < MW'(still_sq_q);
    cls_q.impact <= mag_q > MW'(imp_sq_q);
    cls_q.rearm  <= mag_q > MW'(rearm_sq_q);
    cls_q.clear  <= c3_q;
  end

  assign valid_o    = v4_q;
  assign cls_o      = cls_q;
  assign inflight_o = FRONT_CW'(v1_q) + FRONT_CW'(v2_q) + FRONT_CW'(v3_q)
                    + FRONT_CW'(v4_q);

endmodule

@@ hw/rtl/afd_back.sv @@
// ----------------------------------------------------------------------------
// afd_back
// Phase FSM with still-sample counter; one item per cycle while out_ready_i.
// ----------------------------------------------------------------------------
module afd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [afd_pkg::CFG_W-1:0]  confirm_i,
  input  logic                       valid_i,
  input  afd_pkg::afd_class_t        cls_i,
  input  logic                       out_ready_i,
  output logic                       step_o,
  output afd_pkg::afd_result_t       res_o
);

  import afd_pkg::*;

  afd_phase_e       phase_q, phase_d, phase_n;
  logic [CFG_W-1:0] count_q, count_d, count_n, count_inc;

  assign step_o    = valid_i && out_ready_i;
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

  // next state
  always_comb begin
    phase_n = phase_q;
    count_n = count_q;
    unique case (phase_q)
      PH_NORMAL: begin
        if (cls_i.impact) begin
          phase_n = PH_IMPACT;
          count_n = '0;
        end
      end
      PH_IMPACT: begin
        priority if (cls_i.still) begin
          count_n = count_inc;
          if (count_inc >= confirm_i) begin
            phase_n = PH_FALLEN;
          end
        end else if (cls_i.impact) begin
          count_n = '0;
        end else begin
          phase_n = PH_NORMAL;
          count_n = '0;
        end
      end
      PH_FALLEN: begin
        if (cls_i.rearm) begin
          phase_n = PH_NORMAL;
          count_n = '0;
        end
      end
      default: begin
        phase_n = PH_NORMAL;
        count_n = '0;
      end
    endcase
    if (cls_i.clear) begin
      phase_n = PH_NORMAL;
      count_n = '0;
    end
    phase_d = step_o ? phase_n : phase_q;
    count_d = step_o ? count_n : count_q;
  end

  // result item
  always_comb begin
    res_o.fallen  = (phase_n == PH_FALLEN);
    res_o.phase   = phase_n;
    res_o.changed = (phase_n == PH_FALLEN) != (phase_q == PH_FALLEN);
    res_o.rearm   = (phase_q == PH_FALLEN) && (phase_n != PH_FALLEN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

endmodule

@@ hw/rtl/accel_fall_detector.sv @@
// ----------------------------------------------------------------------------
// accel_fall_detector
// Impact-then-stillness fall detector on three-axis accelerometer samples.
// ----------------------------------------------------------------------------
// Takes one sample per clock while full is low and returns one result item
// per sample, in order. A four-stage classifier (absolute value, squares, sum,
// threshold compares) feeds an eight-entry queue; the phase state machine
// drains it one item per cycle, while the result queue can take one, into a
// two-entry result queue. full goes high while eight items sit in the
// classifier and the middle queue together, so results left untaken stall
// input after about ten items. A register write applies to every sample
// accepted after it; write only while no item is in flight.
module accel_fall_detector #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [afd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [afd_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic signed [SAMPLE_BITS-1:0]   accel_x_i,
  input  logic signed [SAMPLE_BITS-1:0]   accel_y_i,
  input  logic signed [SAMPLE_BITS-1:0]   accel_z_i,
  input  logic                            manual_clear_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            fallen_o,
  output logic [1:0]                      phase_now_o,
  output logic                            status_changed_o,
  output logic                            alert_rearm_o
);

  import afd_pkg::*;

  localparam int unsigned CW_W  = $bits(afd_class_t);
  localparam int unsigned RES_W = $bits(afd_result_t);
  localparam int unsigned OUT_CW = $clog2(OUT_DEPTH + 1);

  afd_cfg_t cfg_q;

  logic                in_acc;
  logic                front_valid;
  afd_class_t          front_cls;
  logic [FRONT_CW-1:0] inflight;

  logic [CW_W-1:0]   mid_rdata;
  logic [MID_CW-1:0] mid_count;
  logic              mid_empty, mid_full;
  logic [MID_CW:0]   pending;

  logic              step;
  afd_result_t       res, out_res;
  logic [RES_W-1:0]  out_rdata;
  logic [OUT_CW-1:0] out_count;
  logic              out_empty, out_full, out_ready, out_pop;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.impact  <= IMPACT_RST;
      cfg_q.still   <= STILL_RST;
      cfg_q.confirm <= CONFIRM_RST;
      cfg_q.rearm   <= REARM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IMPACT:  cfg_q.impact  <= cfg_data_i;
        REG_STILL:   cfg_q.still   <= cfg_data_i;
        REG_CONFIRM: cfg_q.confirm <= cfg_data_i;
        REG_REARM:   cfg_q.rearm   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // admit only what the middle queue can always absorb
  assign pending = (MID_CW + 1)'(mid_count) + (MID_CW + 1)'(inflight);
  assign full    = (pending >= (MID_CW + 1)'(MID_DEPTH));
  assign in_acc  = push && !full;

  afd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (in_acc),
    .accel_x_i  (accel_x_i),
    .accel_y_i  (accel_y_i),
    .accel_z_i  (accel_z_i),
    .clear_i    (manual_clear_i),
    .valid_o    (front_valid),
    .cls_o      (front_cls),
    .inflight_o (inflight)
  );

  afd_fifo #(
    .WIDTH (CW_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (front_valid),
    .wdata_i (front_cls),
    .rd_i    (step),
    .rdata_o (mid_rdata),
    .count_o (mid_count),
    .empty_o (mid_empty),
    .full_o  (mid_full)
  );

  assign out_pop   = pop && !out_empty;
  assign out_ready = !out_full || out_pop;

  afd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .confirm_i   (cfg_q.confirm),
    .valid_i     (!mid_empty),
    .cls_i       (afd_class_t'(mid_rdata)),
    .out_ready_i (out_ready),
    .step_o      (step),
    .res_o       (res)
  );

  afd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (step),
    .wdata_i (res),
    .rd_i    (out_pop),
    .rdata_o (out_rdata),
    .count_o (out_count),
    .empty_o (out_empty),
    .full_o  (out_full)
  );

  assign out_res          = afd_result_t'(out_rdata);
  assign empty            = out_empty;
  assign fallen_o         = out_res.fallen;
  assign phase_now_o      = out_res.phase;
  assign status_changed_o = out_res.changed;
  assign alert_rearm_o    = out_res.rearm;

`ifndef SYNTHESIS
  // the admission rule must keep the middle queue from overflowing
  a_mid_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_valid |-> !mid_full)
    else $error("classified item dropped at full middle queue");

  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> (out_count != OUT_CW'(OUT_DEPTH)) || out_pop)
    else $error("result item written into full result queue");

  // leaving the fallen phase always flips the fallen flag
  a_rearm_changes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.rearm) |-> (res.changed && !res.fallen))
    else $error("rearm without fallen status change");
`endif

endmodule
